>>> rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg: shared constants and types of the selective repeat receiver
// Sequence space, packet sizes, header content types, reply kinds,
// received-map row geometry, RAM request and zero-search result types.
// ----------------------------------------------------------------------------
package srr_pkg;

	localparam int SEQ_SPACE  = 65536;
	localparam int MAX_PACKET = 500;
	localparam int HDR_BYTES  = 16;
	localparam int PAYLOAD    = MAX_PACKET - HDR_BYTES;

	localparam int SEQ_W = 16;
	localparam int PTR_W = 17;

	// header content types
	localparam logic [15:0] T_DATA    = 16'd0;
	localparam logic [15:0] T_ACK     = 16'd1;
	localparam logic [15:0] T_FIN     = 16'd2;
	localparam logic [15:0] T_FIN_ACK = 16'd3;

	// reply kinds
	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_FIN_ACK = 2'd1,
		KIND_CLOSED  = 2'd2
	} reply_kind_t;

	// received map is kept as rows of ROW_W flags
	localparam int ROW_W  = 8;
	localparam int ROW_LG = $clog2(ROW_W);
	localparam int ROWS   = (SEQ_SPACE + ROW_W - 1) / ROW_W;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [ROW_AW-1:0] row_addr_t;

	typedef struct packed {
		logic      we;
		row_addr_t waddr;
		row_t      wdata;
		row_addr_t raddr;
	} ram_req_t;

	typedef struct packed {
		logic              found;
		logic [ROW_LG-1:0] pos;
	} zf_t;

endpackage

>>> rtl/srr_map_ram.sv
// ----------------------------------------------------------------------------
// srr_map_ram: received-map storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srr_map_ram (
	input  logic              clk,
	input  srr_pkg::ram_req_t req,
	output srr_pkg::row_t     rdata
);

	srr_pkg::row_t mem [srr_pkg::ROWS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

>>> rtl/srr_zero_find.sv
// ----------------------------------------------------------------------------
// srr_zero_find: first clear flag in a map row
// Finds the lowest clear bit at or above a start position.
// ----------------------------------------------------------------------------
module srr_zero_find (
	input  srr_pkg::row_t                 word,
	input  logic [srr_pkg::ROW_LG-1:0]    start,
	output srr_pkg::zf_t                  res
);

	always_comb begin
		res = '0;
		for (int i = srr_pkg::ROW_W - 1; i >= 0; i--) begin
			if (!word[i] && (i >= int'(start))) begin
				res.found = 1'b1;
				res.pos   = srr_pkg::ROW_LG'(i);
			end
		end
	end

endmodule

>>> rtl/selective_repeat_receiver.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver: header-level selective repeat ARQ receiver
// Tracks received sequence numbers, issues payload store commands and
// builds ACK / FIN_ACK replies.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. After
// reset the received map is cleared one row of 8 flags per cycle, all 8192
// rows with busy high, before the first request is taken. Requests that
// need no map access (FIN, FIN_ACK resends, close, drops) finish as they
// are taken: busy stays low. A DATA request runs a map row read, then check
// and mark, plus one walk step for each further map row the next-expected
// pointer walks over; the walk only runs when the new packet fills the slot
// the pointer sits on. The map RAM's single read port and its registered
// read data set these steps. A result appears for exactly one cycle with
// result_strobe high; the receiver cannot be stalled and the consumer must
// take it then.
// ----------------------------------------------------------------------------
module selective_repeat_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [8:0]  packet_length,
	input  logic [63:0] origin_time,
	input  logic [15:0] packet_type,
	input  logic [15:0] sequence_number,
	output logic        result_strobe,
	output logic [1:0]  reply_kind,
	output logic [15:0] reply_sequence,
	output logic [63:0] reply_time,
	output logic        store_payload,
	output logic [24:0] store_offset,
	output logic [8:0]  store_length,
	output logic [16:0] next_expected,
	output logic signed [16:0] highest_acked
);

	localparam int PTR_W  = srr_pkg::PTR_W;
	localparam int SEQ_W  = srr_pkg::SEQ_W;
	localparam int ROW_LG = srr_pkg::ROW_LG;
	localparam int ROW_AW = srr_pkg::ROW_AW;
	// largest offset (65535 * 484) fits in 25 bits
	localparam int OFF_PW = 25;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_MARK,
		S_WALK
	} state_t;

	typedef enum logic [1:0] {
		PH_RECEIVING,
		PH_FIN_WAIT,
		PH_CLOSED
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	logic [ROW_AW-1:0] clr_q;
	logic [PTR_W-1:0]  ptr_q;
	logic signed [PTR_W-1:0] hi_q;
	logic [SEQ_W-1:0]  fin_seq_q;
	logic [63:0]       fin_time_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [63:0]       time_q;
	logic [8:0]        plen_q;

	srr_pkg::ram_req_t ram_req;
	srr_pkg::row_t     rd_word;
	srr_pkg::row_t     fw_word;
	srr_pkg::row_t     mark_mask;
	srr_pkg::zf_t      zf;

	logic [8:0]        plen_c;
	logic              accept;
	logic              hit;
	logic              seq_gt;
	logic signed [PTR_W-1:0] hi_new;
	logic [PTR_W-1:0]  ptr_found;
	logic [PTR_W-1:0]  ptr_skip;
	logic [PTR_W-1:0]  ptr_nx;
	logic              walk_more;
	logic [SEQ_W-1:0]  seq_in_row;
	logic [SEQ_W-1:0]  seq_q_row;
	logic [PTR_W-1:0]  ptr_nx_row;
	logic [OFF_PW-1:0] prod;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// oversized datagrams are truncated by the receive buffer
	assign plen_c = (int'(packet_length) > srr_pkg::MAX_PACKET) ?
		9'(srr_pkg::MAX_PACKET) : packet_length;

	// mark check on the row read for the current item
	assign mark_mask = srr_pkg::row_t'(1) << seq_q[ROW_LG-1:0];
	assign hit       = rd_word[seq_q[ROW_LG-1:0]];
	// in the mark cycle the pointer row is the row just updated: forward it
	assign fw_word   = (state_q == S_MARK) ? (rd_word | mark_mask) : rd_word;

	srr_zero_find u_zf (
		.word  (fw_word),
		.start (ptr_q[ROW_LG-1:0]),
		.res   (zf)
	);

	assign ptr_found = {ptr_q[PTR_W-1:ROW_LG], zf.pos};
	assign ptr_skip  = {(ptr_q[PTR_W-1:ROW_LG] + 1'b1), ROW_LG'(0)};
	assign ptr_nx    = zf.found ? ptr_found : ptr_skip;
	// flags past the sequence space are never set, so a found slot stops there
	assign walk_more = !zf.found && (ptr_skip < PTR_W'(srr_pkg::SEQ_SPACE));

	assign seq_gt = $signed({1'b0, seq_q}) > hi_q;
	assign hi_new = seq_gt ? $signed({1'b0, seq_q}) : hi_q;

	assign prod = OFF_PW'(seq_q) * OFF_PW'(srr_pkg::PAYLOAD);

	assign seq_in_row = sequence_number >> ROW_LG;
	assign seq_q_row  = seq_q >> ROW_LG;
	assign ptr_nx_row = ptr_nx >> ROW_LG;

	always_comb begin
		ram_req       = '0;
		ram_req.raddr = (state_q == S_IDLE) ? seq_in_row[ROW_AW-1:0] :
			ptr_nx_row[ROW_AW-1:0];
		case (state_q)
			S_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = clr_q;
				ram_req.wdata = '0;
			end
			S_MARK: begin
				ram_req.we    = !hit;
				ram_req.waddr = seq_q_row[ROW_AW-1:0];
				ram_req.wdata = rd_word | mark_mask;
			end
			default: begin
				ram_req.we = 1'b0;
			end
		endcase
	end

	srr_map_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			phase_q        <= PH_RECEIVING;
			clr_q          <= '0;
			ptr_q          <= '0;
			hi_q           <= '1;
			fin_seq_q      <= '0;
			fin_time_q     <= '0;
			seq_q          <= '0;
			time_q         <= '0;
			plen_q         <= '0;
			result_strobe  <= 1'b0;
			reply_kind     <= srr_pkg::KIND_ACK;
			reply_sequence <= '0;
			reply_time     <= '0;
			store_payload  <= 1'b0;
			store_offset   <= '0;
			store_length   <= '0;
			next_expected  <= '0;
			highest_acked  <= '1;
		end else begin
			result_strobe <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ROW_AW'(srr_pkg::ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						seq_q  <= sequence_number;
						time_q <= origin_time;
						plen_q <= plen_c;
						case (phase_q)
							PH_FIN_WAIT: begin
								result_strobe <= 1'b1;
								store_payload <= 1'b0;
								store_offset  <= '0;
								store_length  <= '0;
								next_expected <= ptr_q;
								highest_acked <= hi_q;
								if (plen_c == 9'(srr_pkg::HDR_BYTES) &&
										packet_type == srr_pkg::T_ACK) begin
									phase_q        <= PH_CLOSED;
									reply_kind     <= srr_pkg::KIND_CLOSED;
									reply_sequence <= '0;
									reply_time     <= '0;
								end else begin
									reply_kind     <= srr_pkg::KIND_FIN_ACK;
									reply_sequence <= fin_seq_q;
									reply_time     <= fin_time_q;
								end
							end
							PH_RECEIVING: begin
								if (plen_c >= 9'(srr_pkg::HDR_BYTES)) begin
									if (packet_type == srr_pkg::T_FIN) begin
										phase_q        <= PH_FIN_WAIT;
										fin_seq_q      <= sequence_number;
										fin_time_q     <= origin_time;
										result_strobe  <= 1'b1;
										reply_kind     <= srr_pkg::KIND_FIN_ACK;
										reply_sequence <= sequence_number;
										reply_time     <= origin_time;
										store_payload  <= 1'b0;
										store_offset   <= '0;
										store_length   <= '0;
										next_expected  <= ptr_q;
										highest_acked  <= hi_q;
									end else if (packet_type == srr_pkg::T_DATA &&
											({1'b0, sequence_number} <
											PTR_W'(srr_pkg::SEQ_SPACE))) begin
										state_q <= S_MARK;
									end
								end
							end
							default: begin
								// closed: ignore everything
							end
						endcase
					end
				end
				S_MARK: begin
					hi_q           <= hi_new;
					reply_kind     <= srr_pkg::KIND_ACK;
					reply_sequence <= seq_q;
					reply_time     <= time_q;
					highest_acked  <= hi_new;
					store_payload  <= !hit;
					store_offset   <= hit ? 25'd0 : prod;
					store_length   <= hit ? 9'd0 : (plen_q - 9'(srr_pkg::HDR_BYTES));
					if (!hit && ({1'b0, seq_q} == ptr_q)) begin
						ptr_q <= ptr_nx;
						if (walk_more) begin
							state_q <= S_WALK;
						end else begin
							state_q       <= S_IDLE;
							result_strobe <= 1'b1;
							next_expected <= ptr_nx;
						end
					end else begin
						state_q       <= S_IDLE;
						result_strobe <= 1'b1;
						next_expected <= ptr_q;
					end
				end
				S_WALK: begin
					ptr_q <= ptr_nx;
					if (!walk_more) begin
						state_q       <= S_IDLE;
						result_strobe <= 1'b1;
						next_expected <= ptr_nx;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_W'(srr_pkg::SEQ_SPACE))
		else $error("next-expected pointer beyond sequence space");

	a_ptr_mono: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q >= $past(ptr_q))
		else $error("next-expected pointer moved backward");

	a_store_ack: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && store_payload |-> reply_kind == srr_pkg::KIND_ACK)
		else $error("store command without data ACK");

	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> $past(state_q) == S_MARK || $past(state_q) == S_WALK)
		else $error("pointer walk entered without a new mark");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !result_strobe && busy)
		else $error("result or request taken during map clear");
`endif

endmodule

>>> test/selective_repeat_receiver_tb.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver_tb: self-checking bench for the SR ARQ receiver
// Drives datagram header requests through the start/busy handshake and
// predicts every reply. Each strobed reply is checked field by field in
// order. The run covers directed corner cases, then windowed random traffic
// under three idle profiles. A hole-fill sweep makes the next-expected
// pointer walk across many map rows at once. The FIN / FIN_ACK / final ACK
// close sequence ends the run.
// ----------------------------------------------------------------------------

typedef enum {
	PH_RECV,
	PH_FIN_WAIT,
	PH_CLOSED
} rx_phase_t;

typedef struct packed {
	logic [8:0]  length;
	logic [63:0] stamp;
	logic [15:0] ptype;
	logic [15:0] seq;
} request_t;

typedef struct packed {
	srr_pkg::reply_kind_t kind;
	logic [15:0] rseq;
	logic [63:0] rtime;
	logic        store;
	logic [24:0] offset;
	logic [8:0]  slen;
	logic [16:0] next_exp;
	logic [16:0] high;
} reply_t;

// Mirror of the receiver: phase, received map and pointers, plus the queue
// of replies still owed by the block.
class arq_tracker;
	rx_phase_t   phase = PH_RECV;
	bit          seen [srr_pkg::SEQ_SPACE];
	int unsigned exp_ptr = 0;
	int          high_ack = -1;
	logic [15:0] fin_seq = '0;
	logic [63:0] fin_stamp = '0;
	reply_t      pending_replies [$];
	int          faults = 0;

	function string show(reply_t r);
		return $sformatf("kind=%0d seq=%h time=%h store=%b off=%0d len=%0d next=%0d high=%0d",
			r.kind, r.rseq, r.rtime, r.store, r.offset, r.slen, r.next_exp,
			$signed(r.high));
	endfunction

	function void note_fault(string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endfunction

	// Update the mirror for one accepted request; returns 1 when a reply is owed.
	function bit take_request(request_t rq);
		int unsigned plen;
		reply_t      rp;
		bit          owed;
		plen = rq.length;
		if (plen > srr_pkg::MAX_PACKET)
			plen = srr_pkg::MAX_PACKET;   // receive buffer truncates oversized datagrams
		rp = '0;
		owed = 1'b0;
		case (phase)
		PH_CLOSED: ;
		PH_FIN_WAIT: begin
			owed = 1'b1;
			if (plen == srr_pkg::HDR_BYTES && rq.ptype == srr_pkg::T_ACK) begin
				phase = PH_CLOSED;
				rp.kind = srr_pkg::KIND_CLOSED;
			end else begin
				rp.kind = srr_pkg::KIND_FIN_ACK;
				rp.rseq = fin_seq;
				rp.rtime = fin_stamp;
			end
		end
		PH_RECV: begin
			if (plen >= srr_pkg::HDR_BYTES && rq.ptype == srr_pkg::T_FIN) begin
				fin_seq = rq.seq;
				fin_stamp = rq.stamp;
				phase = PH_FIN_WAIT;
				owed = 1'b1;
				rp.kind = srr_pkg::KIND_FIN_ACK;
				rp.rseq = rq.seq;
				rp.rtime = rq.stamp;
			end else if (plen >= srr_pkg::HDR_BYTES && rq.ptype == srr_pkg::T_DATA) begin
				owed = 1'b1;
				rp.kind = srr_pkg::KIND_ACK;
				rp.rseq = rq.seq;
				rp.rtime = rq.stamp;
				if (!seen[rq.seq]) begin
					seen[rq.seq] = 1'b1;
					rp.store = 1'b1;
					rp.offset = 25'(rq.seq * srr_pkg::PAYLOAD);
					rp.slen = 9'(plen - srr_pkg::HDR_BYTES);
					while (exp_ptr < srr_pkg::SEQ_SPACE && seen[exp_ptr])
						exp_ptr++;
				end
				if (int'(rq.seq) > high_ack)
					high_ack = int'(rq.seq);
			end
		end
		endcase
		if (owed) begin
			rp.next_exp = 17'(exp_ptr);
			rp.high = 17'(high_ack);
			pending_replies.push_back(rp);
		end
		return owed;
	endfunction

	function void check_reply(reply_t got);
		reply_t want;
		if (pending_replies.size() == 0) begin
			note_fault({"unexpected reply: ", show(got)});
			return;
		end
		want = pending_replies.pop_front();
		if (got.kind !== want.kind || got.rseq !== want.rseq || got.rtime !== want.rtime ||
				got.store !== want.store || got.offset !== want.offset ||
				got.slen !== want.slen || got.next_exp !== want.next_exp ||
				got.high !== want.high)
			note_fault({"reply mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
	endfunction
endclass

module selective_repeat_receiver_tb;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [8:0]  packet_length;
	logic [63:0] origin_time;
	logic [15:0] packet_type;
	logic [15:0] sequence_number;
	logic        result_strobe;
	logic [1:0]  reply_kind;
	logic [15:0] reply_sequence;
	logic [63:0] reply_time;
	logic        store_payload;
	logic [24:0] store_offset;
	logic [8:0]  store_length;
	logic [16:0] next_expected;
	logic signed [16:0] highest_acked;

	arq_tracker sb;

	selective_repeat_receiver u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.packet_length   (packet_length),
		.origin_time     (origin_time),
		.packet_type     (packet_type),
		.sequence_number (sequence_number),
		.result_strobe   (result_strobe),
		.reply_kind      (reply_kind),
		.reply_sequence  (reply_sequence),
		.reply_time      (reply_time),
		.store_payload   (store_payload),
		.store_offset    (store_offset),
		.store_length    (store_length),
		.next_expected   (next_expected),
		.highest_acked   (highest_acked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop as a watchdog: a correct run ends well before it (map clear,
	// about a thousand requests with idle gaps, walks bounded by one map pass).
	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Reply monitor. The strobe lasts exactly one cycle and cannot be held
	// off, so every edge with the strobe high is one reply.
	always @(posedge clk) begin : reply_watch
		reply_t got;
		if (arst_n && result_strobe === 1'b1) begin
			got.kind = srr_pkg::reply_kind_t'(reply_kind);
			got.rseq = reply_sequence;
			got.rtime = reply_time;
			got.store = store_payload;
			got.offset = store_offset;
			got.slen = store_length;
			got.next_exp = next_expected;
			got.high = highest_acked;
			sb.check_reply(got);
		end
	end

	function automatic request_t mk(logic [8:0] len, logic [15:0] ptype, logic [15:0] seq,
			logic [63:0] stamp);
		request_t rq;
		rq.length = len;
		rq.ptype = ptype;
		rq.seq = seq;
		rq.stamp = stamp;
		return rq;
	endfunction

	// Fully random header, biased toward the defined types.
	function automatic request_t any_request();
		request_t rq;
		rq.length = 9'($urandom_range(0, 511));
		rq.ptype = $urandom_range(1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
		rq.seq = 16'($urandom);
		rq.stamp = {$urandom, $urandom};
		return rq;
	endfunction

	// One request: optional idle gap, then hold start until the edge where
	// busy is low. The mirror is updated at that edge, in this process, so
	// stimulus choices always see the up to date pointer and map.
	task automatic send_request(input request_t rq, input int idle_pct, output bit replied);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		packet_length <= rq.length;
		origin_time <= rq.stamp;
		packet_type <= rq.ptype;
		sequence_number <= rq.seq;
		do @(posedge clk); while (busy !== 1'b0);
		replied = sb.take_request(rq);
	endtask

	// Receiving-phase traffic: mostly DATA in a small window above the
	// next-expected pointer (so the pointer walks), some duplicates, some far
	// sequence numbers, plus short packets and non-DATA types as noise.
	// FIN of header size or more is never sent here, it would end the phase.
	task automatic run_receiving(input int replies_wanted, input int idle_pct);
		request_t rq;
		bit       replied;
		int       got;
		int       pick;
		got = 0;
		while (got < replies_wanted) begin
			pick = $urandom_range(99);
			rq.stamp = {$urandom, $urandom};
			rq.length = 9'($urandom_range(srr_pkg::HDR_BYTES, srr_pkg::MAX_PACKET));
			if ($urandom_range(9) == 0)
				rq.length = 9'($urandom_range(srr_pkg::MAX_PACKET + 1, 511));
			else if ($urandom_range(19) == 0)
				rq.length = 9'(srr_pkg::HDR_BYTES);
			rq.ptype = srr_pkg::T_DATA;
			if (pick < 70) begin
				rq.seq = 16'(sb.exp_ptr + $urandom_range(0, $urandom_range(1, 24)));
			end else if (pick < 80) begin
				if (sb.exp_ptr > 32)
					rq.seq = 16'(sb.exp_ptr - $urandom_range(1, 32));
				else
					rq.seq = 16'($urandom_range(0, sb.exp_ptr));
			end else if (pick < 83) begin
				rq.seq = 16'($urandom);
			end else if (pick < 88) begin
				rq.length = 9'($urandom_range(0, srr_pkg::HDR_BYTES - 1));
				rq.ptype = 16'($urandom_range(1) ? $urandom_range(0, 3) : $urandom);
				rq.seq = 16'($urandom);
			end else begin
				case ($urandom_range(2))
				0: rq.ptype = srr_pkg::T_ACK;
				1: rq.ptype = srr_pkg::T_FIN_ACK;
				default: rq.ptype = 16'($urandom_range(4, 65535));
				endcase
				rq.seq = 16'($urandom);
			end
			send_request(rq, idle_pct, replied);
			if (replied)
				got++;
		end
	endtask

	initial begin
		request_t rq;
		bit       replied;
		int       hole;
		sb = new;
		arst_n <= 1'b0;
		start <= 1'b0;
		packet_length <= '0;
		origin_time <= '0;
		packet_type <= '0;
		sequence_number <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed corners. The first request also waits out the map clear.
		send_request(mk(16, srr_pkg::T_DATA, 0, 64'h0), 0, replied);      // empty payload
		send_request(mk(500, srr_pkg::T_DATA, 1, 64'hFFFF_FFFF_FFFF_FFFF), 0, replied);
		send_request(mk(511, srr_pkg::T_DATA, 2, 64'h8000_0000_0000_0001), 0,
			replied);                                                       // truncated
		send_request(mk(501, srr_pkg::T_DATA, 4, 64'h0123_4567_89AB_CDEF), 0,
			replied);                                                       // gap at 3
		send_request(mk(17, srr_pkg::T_DATA, 3, 64'hFEDC_BA98_7654_3210), 0,
			replied);                                                       // fills gap
		send_request(mk(200, srr_pkg::T_DATA, 1, 64'h5555_5555_5555_5555), 0,
			replied);                                                       // duplicate
		send_request(mk(15, srr_pkg::T_DATA, 5, 64'h1), 0, replied);      // short, dropped
		send_request(mk(0, srr_pkg::T_DATA, 5, 64'h2), 0, replied);
		send_request(mk(16, srr_pkg::T_ACK, 5, 64'h3), 0, replied);       // ignored types
		send_request(mk(100, srr_pkg::T_FIN_ACK, 5, 64'h4), 0, replied);
		send_request(mk(300, 16'hFFFF, 16'hFFFF, 64'h5), 0, replied);
		send_request(mk(16, 16'd4, 5, 64'h6), 0, replied);
		send_request(mk(15, srr_pkg::T_FIN, 9, 64'h7), 0, replied);       // short FIN
		// reverse fill across a map row boundary, then the pointer walks 5 -> 13
		for (int s = 12; s >= 5; s--)
			send_request(mk(9'(srr_pkg::HDR_BYTES + s), srr_pkg::T_DATA, 16'(s),
				{$urandom, $urandom}), 0, replied);

		// random traffic under three idle profiles
		run_receiving(220, 17);
		run_receiving(220, 70);
		run_receiving(220, 0);

		// Hole fill: set every missing sequence in a stretch above the pointer,
		// leaving the pointer slot open, then fill it so the pointer walks
		// across many map rows at once.
		hole = sb.exp_ptr;
		for (int s = hole + 1; s < hole + 80 && s < srr_pkg::SEQ_SPACE; s++)
			if (!sb.seen[s])
				send_request(mk(9'($urandom_range(srr_pkg::HDR_BYTES, 511)),
					srr_pkg::T_DATA, 16'(s), {$urandom, $urandom}), 0, replied);
		send_request(mk(9'($urandom_range(srr_pkg::HDR_BYTES, 511)), srr_pkg::T_DATA,
			16'(hole), {$urandom, $urandom}), 0, replied);
		// top of the sequence space, then a duplicate of sequence 0
		send_request(mk(500, srr_pkg::T_DATA, 16'hFFFF, {$urandom, $urandom}), 0, replied);
		send_request(mk(16, srr_pkg::T_DATA, 0, {$urandom, $urandom}), 0, replied);

		// FIN, then everything but a header-sized ACK gets the saved FIN_ACK
		send_request(mk(9'($urandom_range(srr_pkg::HDR_BYTES, 511)), srr_pkg::T_FIN,
			16'($urandom), {$urandom, $urandom}), 17, replied);
		send_request(mk(15, srr_pkg::T_ACK, 1, 64'h10), 17, replied);
		send_request(mk(17, srr_pkg::T_ACK, 1, 64'h11), 17, replied);
		send_request(mk(0, srr_pkg::T_ACK, 1, 64'h12), 17, replied);
		send_request(mk(511, srr_pkg::T_ACK, 1, 64'h13), 17, replied);
		send_request(mk(16, srr_pkg::T_FIN, 2, 64'h14), 17, replied);
		send_request(mk(16, srr_pkg::T_DATA, 3, 64'h15), 17, replied);
		repeat (30) begin
			rq = any_request();
			if (rq.ptype == srr_pkg::T_ACK && rq.length == 9'(srr_pkg::HDR_BYTES))
				rq.length = 9'(srr_pkg::HDR_BYTES + 1);
			send_request(rq, 17, replied);
		end
		send_request(mk(16, srr_pkg::T_ACK, 16'($urandom), {$urandom, $urandom}), 17,
			replied);

		// closed: all further requests are ignored
		send_request(mk(16, srr_pkg::T_ACK, 0, 64'h20), 17, replied);
		send_request(mk(100, srr_pkg::T_DATA, 0, 64'h21), 17, replied);
		repeat (8)
			send_request(any_request(), 17, replied);
		start <= 1'b0;

		// drain, then a quiet stretch to catch stray replies
		while (sb.pending_replies.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.faults == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
